// ===== hw/rtl/rrbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbm_pkg
// Shared sizes, item types, request and status codes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rrbm_pkg;

    // Store geometry
    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 16;

    // Fixed item field widths
    localparam int DATA_W   = 16;
    localparam int FILL_W   = 7;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_MINMAX = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Input item
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DATA_W-1:0] new_value;
        logic [DATA_W-1:0] read_index;
    } req_t;

    // Result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_value;
        logic [DATA_W-1:0]   min_value;
        logic [DATA_W-1:0]   max_value;
        logic [FILL_W-1:0]   fill_level;
    } rsp_t;

    // Controller states
    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_DECODE,
        CTL_SCAN_FIRST,
        CTL_SCAN,
        CTL_FINISH
    } ctl_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic cap_req;     // latch accepted item
        logic do_write;    // insert at write pointer
        logic do_clear;    // zero pointer and count
        logic rd_age;      // read slot of requested age
        logic rd_scan;     // read slot of scan age, advance scan
        logic fold_first;  // load min/max from read data
        logic fold;        // merge read data into min/max
        logic out_load;    // load result register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        req_kind_t req_kind;
        logic      idx_ok;
        logic      empty;
        logic      scan_more;
        logic      out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/recency_ring_buffer_minmax_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// recency_ring_buffer_minmax_top
// Ring store of measurements with insert, read by age, min/max scan and clear.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   input    | in_valid / in_stall   | in_item  (req_t)
//   output   | out_valid / out_stall | out_item (rsp_t)
//
// Insert, clear and read by age go through the decode and finish states.
// Min/max on a non-empty ring adds the scan states before finish: the scan reads one
// entry per cycle through the single read port of the value memory.
// Reset marks every entry unwritten in per-entry valid bits; no clearing pass.
// A result waiting on out_stall holds the controller in its finish state.
// ----------------------------------------------------------------------------
module recency_ring_buffer_minmax_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire rrbm_pkg::req_t in_item,
    output logic               out_valid,
    input  wire logic          out_stall,
    output rrbm_pkg::rsp_t     out_item
);
    import rrbm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    rrbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store and result path
    rrbm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/rrbm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbm_ctrl
// Request sequencer: decodes each item, steps the min/max scan one entry per
// cycle and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module rrbm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire rrbm_pkg::sts_t sts,
    output rrbm_pkg::cmd_t     cmd
);
    import rrbm_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            CTL_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.cap_req = in_valid;
                if (in_valid)
                begin
                    state_next = CTL_DECODE;
                end
            end
            CTL_DECODE:
            begin
                state_next = CTL_FINISH;
                case (sts.req_kind)
                    REQ_INSERT: cmd.do_write = 1'b1;
                    REQ_CLEAR:  cmd.do_clear = 1'b1;
                    REQ_READ:   cmd.rd_age   = sts.idx_ok;
                    REQ_MINMAX:
                    begin
                        if (!sts.empty)
                        begin
                            cmd.rd_scan = 1'b1;
                            state_next  = CTL_SCAN_FIRST;
                        end
                    end
                    default: state_next = CTL_FINISH;
                endcase
            end
            CTL_SCAN_FIRST, CTL_SCAN:
            begin
                // data of the read issued last cycle is merged here
                cmd.fold_first = (state_reg == CTL_SCAN_FIRST);
                cmd.fold       = (state_reg == CTL_SCAN);
                if (sts.scan_more)
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = CTL_SCAN;
                end
                else
                begin
                    state_next = CTL_FINISH;
                end
            end
            CTL_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = CTL_IDLE;
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rrbm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbm_dp
// Datapath: value memory with per-entry valid bits, write pointer, fill
// count, scan counter, min/max accumulators and the output register.
// ----------------------------------------------------------------------------
module rrbm_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rrbm_pkg::req_t in_item,
    output logic               out_valid,
    input  wire logic          out_stall,
    output rrbm_pkg::rsp_t     out_item,
    input  wire rrbm_pkg::cmd_t cmd,
    output rrbm_pkg::sts_t     sts
);
    import rrbm_pkg::*;

    // Slot holding the entry 'age' places back from the newest
    function automatic logic [PTR_W-1:0] slot_of_age(
        input logic [PTR_W-1:0] wp,
        input logic [PTR_W-1:0] age
    );
        logic [PTR_W:0] back;
        logic [PTR_W:0] diff;
        back = {1'b0, age} + (PTR_W+1)'(1);
        if ({1'b0, wp} >= back)
        begin
            diff = {1'b0, wp} - back;
        end
        else
        begin
            diff = {1'b0, wp} + (PTR_W+1)'(DEPTH) - back;
        end
        return diff[PTR_W-1:0];
    endfunction

    logic [STORE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;

    req_t               req_reg;
    logic [PTR_W-1:0]   wp_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   scan_age_reg;
    logic [STORE_W-1:0] rdata_reg;
    logic               rvalid_reg;
    logic [STORE_W-1:0] min_reg;
    logic [STORE_W-1:0] max_reg;
    logic               out_valid_reg;
    rsp_t               out_item_reg;

    req_kind_t          req_kind;
    logic               idx_ok;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [STORE_W-1:0] rd_value;
    logic               out_free;
    rsp_t               rsp;

    assign req_kind = req_kind_t'(req_reg.req_type);
    assign idx_ok   = (32'(req_reg.read_index) < 32'(DEPTH));
    assign out_free = !out_valid_reg || !out_stall;

    // Read address: scan age or requested age
    assign rd_en   = cmd.rd_age || cmd.rd_scan;
    assign rd_addr = cmd.rd_scan ? slot_of_age(wp_reg, scan_age_reg[PTR_W-1:0])
                                 : slot_of_age(wp_reg, req_reg.read_index[PTR_W-1:0]);

    // Never-written entries read as zero
    assign rd_value = rvalid_reg ? rdata_reg : '0;

    // Status to controller
    always_comb
    begin
        sts.req_kind  = req_kind;
        sts.idx_ok    = idx_ok;
        sts.empty     = (cnt_reg == '0);
        sts.scan_more = (scan_age_reg < cnt_reg);
        sts.out_free  = out_free;
    end

    // Value memory
    always_ff @(posedge clk)
    begin
        if (cmd.do_write)
        begin
            mem[wp_reg] <= req_reg.new_value[STORE_W-1:0];
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Accepted item and accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            req_reg <= in_item;
        end
        if (cmd.fold_first)
        begin
            min_reg <= rd_value;
            max_reg <= rd_value;
        end
        else if (cmd.fold)
        begin
            if (rd_value < min_reg)
            begin
                min_reg <= rd_value;
            end
            if (rd_value > max_reg)
            begin
                max_reg <= rd_value;
            end
        end
        if (cmd.out_load)
        begin
            out_item_reg <= rsp;
        end
    end

    // Pointer, count, valid bits, scan counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            scan_age_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
            if (cmd.do_write)
            begin
                valid_reg[wp_reg] <= 1'b1;
                wp_reg <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                if (cnt_reg != CNT_W'(DEPTH))
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            else if (cmd.do_clear)
            begin
                wp_reg  <= '0;
                cnt_reg <= '0;
            end
            if (cmd.cap_req)
            begin
                scan_age_reg <= '0;
            end
            else if (cmd.rd_scan)
            begin
                scan_age_reg <= scan_age_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result assembly
    always_comb
    begin
        rsp            = '0;
        rsp.status     = ST_OK;
        rsp.fill_level = FILL_W'(cnt_reg);
        case (req_kind)
            REQ_READ:
            begin
                if (idx_ok)
                begin
                    rsp.read_value = DATA_W'(rd_value);
                end
                else
                begin
                    rsp.status = ST_RANGE;
                end
            end
            REQ_MINMAX:
            begin
                if (cnt_reg == '0)
                begin
                    rsp.status = ST_EMPTY;
                end
                else
                begin
                    rsp.min_value = DATA_W'(min_reg);
                    rsp.max_value = DATA_W'(max_reg);
                end
            end
            default: rsp.status = ST_OK;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

// ===== dv/recency_ring_buffer_minmax_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recency_ring_buffer_minmax_top_test
// Self-checking bench for the measurement ring. A scoreboard class keeps its
// own copy of the ring (slots, write pointer, fill count), predicts one
// response per accepted request and checks responses in order. Stimulus is a
// short directed pass over empty, full-range and cleared cases, then random
// fill and mixed episodes with random gaps, random output stalls and one long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module recency_ring_buffer_minmax_top_test;
    import rrbm_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;

    // Ring predictor plus in-order response check
    class ring_answer_board;
        logic [STORE_W-1:0] slots[DEPTH];
        logic [PTR_W-1:0]   wr_ptr;
        logic [CNT_W-1:0]   held;
        rsp_t               pending_answers[$];
        int                 mismatches;
        int                 checked;
        int                 n_insert, n_read, n_minmax, n_clear;
        int                 n_range, n_empty, n_full_scan, n_wrap;

        function new();
            foreach (slots[i]) slots[i] = '0;
            wr_ptr = '0;
            held = '0;
            mismatches = 0;
            checked = 0;
            n_insert = 0; n_read = 0; n_minmax = 0; n_clear = 0;
            n_range = 0; n_empty = 0; n_full_scan = 0; n_wrap = 0;
        endfunction

        // age 0 is the newest entry, one slot behind the write pointer
        function int slot_for_age(int age);
            return (int'(wr_ptr) + DEPTH - ((age + 1) % DEPTH)) % DEPTH;
        endfunction

        function void note_request(req_t r);
            rsp_t               a;
            logic [STORE_W-1:0] lo, hi, v;
            a = '0;
            a.status = ST_OK;
            case (req_kind_t'(r.req_type))
                REQ_INSERT:
                begin
                    n_insert++;
                    slots[wr_ptr] = r.new_value[STORE_W-1:0];
                    if (int'(wr_ptr) == DEPTH - 1)
                    begin
                        wr_ptr = '0;
                        n_wrap++;
                    end
                    else
                        wr_ptr = wr_ptr + 1'b1;
                    if (int'(held) < DEPTH)
                        held = held + 1'b1;
                end
                REQ_READ:
                begin
                    n_read++;
                    if (int'(r.read_index) < DEPTH)
                        a.read_value = DATA_W'(slots[slot_for_age(int'(r.read_index))]);
                    else
                    begin
                        a.status = ST_RANGE;
                        n_range++;
                    end
                end
                REQ_MINMAX:
                begin
                    n_minmax++;
                    if (held == '0)
                    begin
                        a.status = ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        if (int'(held) == DEPTH)
                            n_full_scan++;
                        lo = slots[slot_for_age(0)];
                        hi = lo;
                        for (int i = 1; i < int'(held); i++)
                        begin
                            v = slots[slot_for_age(i)];
                            if (v < lo) lo = v;
                            if (v > hi) hi = v;
                        end
                        a.min_value = DATA_W'(lo);
                        a.max_value = DATA_W'(hi);
                    end
                end
                default:
                begin
                    // clear keeps the stored values
                    n_clear++;
                    wr_ptr = '0;
                    held = '0;
                end
            endcase
            a.fill_level = FILL_W'(held);
            pending_answers.push_back(a);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] response with no request pending: st=%0d rd=%h mn=%h mx=%h fill=%0d",
                             $time, got.status, got.read_value, got.min_value,
                             got.max_value, got.fill_level);
                return;
            end
            want = pending_answers.pop_front();
            checked++;
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.min_value !== want.min_value || got.max_value !== want.max_value ||
                got.fill_level !== want.fill_level)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] response %0d: want st=%0d rd=%h mn=%h mx=%h fill=%0d, got st=%0d rd=%h mn=%h mx=%h fill=%0d",
                             $time, checked, want.status, want.read_value, want.min_value,
                             want.max_value, want.fill_level, got.status, got.read_value,
                             got.min_value, got.max_value, got.fill_level);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_item;
    logic out_valid;
    logic out_stall;
    rsp_t out_item;

    ring_answer_board board;
    int               cycles;
    bit               hold_now;
    bit               hold_done;

    recency_ring_buffer_minmax_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("run limit of %0d cycles reached, %0d responses outstanding",
                     CYCLE_LIMIT, board.pending_answers.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic req_t make_item(req_kind_t kind, logic [DATA_W-1:0] v,
                                       logic [DATA_W-1:0] idx);
        req_t r;
        r.req_type   = kind;
        r.new_value  = v;
        r.read_index = idx;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return DATA_W'($urandom);
    endfunction

    // mostly in-range ages, some edges, some anything
    function automatic logic [DATA_W-1:0] rand_index();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 6) return DATA_W'($urandom_range(0, DEPTH - 1));
        if (r == 7)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return DATA_W'(DEPTH - 1);
                2: return DATA_W'(DEPTH);
                default: return '1;
            endcase
        end
        return DATA_W'($urandom);
    endfunction

    // mostly short, now and then long
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one item and hold it until accepted
    task automatic send(req_t r);
        in_valid <= 1'b1;
        in_item  <= r;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(r);
    endtask

    task automatic idle_gap(bit quiet);
        int n;
        n = quiet ? 0 : gap_length();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // response side: check accepted items, then pick the next stall
    initial
    begin
        int  stall_left;
        int  len;
        int  rx_cycles;
        bit  rx_calm;
        stall_left = 0;
        rx_cycles = 0;
        rx_calm = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_response(out_item);
            rx_cycles++;
            if (rx_cycles % 256 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (hold_now && !hold_done)
            begin
                // long hold-off: input side keeps offering and backs up
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!rx_calm && $urandom_range(0, 99) < 20)
            begin
                len = gap_length();
                if (len == 0) len = 1;
                stall_left = len - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // request side
    initial
    begin
        int        n_random;
        int        ep_kind;
        int        ep_len;
        int        w;
        bit        quiet;
        bit        filling;
        req_kind_t kind;

        board = new();
        cycles = 0;
        hold_now = 1'b0;
        hold_done = 1'b0;
        clk = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        out_stall <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, index edges, extremes, clear leftovers
        send(make_item(REQ_MINMAX, '1, '1));               idle_gap(0);
        send(make_item(REQ_READ, '0, '0));                 idle_gap(0);
        send(make_item(REQ_READ, '1, DATA_W'(DEPTH - 1))); idle_gap(0);
        send(make_item(REQ_READ, '0, DATA_W'(DEPTH)));     idle_gap(0);
        send(make_item(REQ_READ, '0, '1));                 idle_gap(0);
        send(make_item(REQ_INSERT, '0, '1));               idle_gap(0);
        send(make_item(REQ_INSERT, '1, '0));               idle_gap(0);
        send(make_item(REQ_INSERT, 16'h8001, 16'h7ffe));   idle_gap(0);
        send(make_item(REQ_MINMAX, '0, '0));               idle_gap(0);
        send(make_item(REQ_READ, '0, 16'd0));              idle_gap(0);
        send(make_item(REQ_READ, '0, 16'd2));              idle_gap(0);
        // in range but never filled
        send(make_item(REQ_READ, '0, 16'd3));              idle_gap(0);
        send(make_item(REQ_CLEAR, '1, '1));                idle_gap(0);
        send(make_item(REQ_READ, '0, 16'd0));              idle_gap(0);
        send(make_item(REQ_READ, '0, DATA_W'(DEPTH - 1))); idle_gap(0);
        send(make_item(REQ_MINMAX, '0, '0));               idle_gap(0);
        send(make_item(REQ_INSERT, 16'h1234, '0));         idle_gap(0);
        send(make_item(REQ_MINMAX, '0, '0));               idle_gap(0);
        // values left over from before the clear
        send(make_item(REQ_READ, '0, DATA_W'(DEPTH - 2))); idle_gap(0);
        send(make_item(REQ_READ, '0, DATA_W'(DEPTH - 3))); idle_gap(0);

        // random episodes: long fills to reach wrap and saturation, short mixes
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            ep_kind = $urandom_range(0, 9);
            filling = (ep_kind < 6);
            ep_len  = filling ? $urandom_range(80, 160) : $urandom_range(15, 50);
            quiet   = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ep_len && n_random < RANDOM_ITEMS; k++)
            begin
                w = $urandom_range(0, 199);
                if (ep_kind == 9 && k == 0)
                    kind = REQ_CLEAR;
                else if (filling)
                    kind = (w < 140) ? REQ_INSERT : (w < 170) ? REQ_READ :
                           (w < 198) ? REQ_MINMAX : REQ_CLEAR;
                else
                    kind = (w < 70) ? REQ_INSERT : (w < 130) ? REQ_READ :
                           (w < 185) ? REQ_MINMAX : REQ_CLEAR;
                send(make_item(kind, rand_value(), rand_index()));
                n_random++;
                if (n_random == HOLD_AT)
                    hold_now = 1'b1;
                idle_gap(quiet);
            end
        end
        in_valid <= 1'b0;

        // drain, then allow one full scan of extra time
        while (board.pending_answers.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 16) @(posedge clk);

        $display("Ran %0d requests: %0d inserts (%0d pointer wraps), %0d reads (%0d out of range), %0d clears",
                 board.checked, board.n_insert, board.n_wrap, board.n_read, board.n_range,
                 board.n_clear);
        $display("%0d min/max scans: %0d on an empty ring, %0d over a full ring; %0d failures",
                 board.n_minmax, board.n_empty, board.n_full_scan, board.mismatches);
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rrbm_pkg.sv
hw/rtl/rrbm_ctrl.sv
hw/rtl/rrbm_dp.sv
hw/rtl/recency_ring_buffer_minmax_top.sv
dv/recency_ring_buffer_minmax_top_test.sv
